// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define RRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a property in the following clock cycle.
`define RRQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/rrq_pkg.sv =====
`default_nettype none

package rrq_pkg;

    localparam int ACTION_W    = 3;
    localparam int POS_W       = 7;
    localparam int TO_W        = 6;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int MAX_ENTRY_W = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_MOVE   = 3'd3,
        ACT_GET    = 3'd4,
        ACT_POP    = 3'd5,
        ACT_CLEAR  = 3'd6
    } action_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/reorderable_ring_queue.sv =====
// A queue of entry words held in one ring-buffer memory and addressed by logical position
// from the head, with append, insert, remove, move, get, pop and clear commands; each
// command item yields exactly one result item carrying success, the entry read and the
// count after the command. Items are handled one at a time. Clear, a failed or unknown
// command and a move to the same position go straight to the result; append writes the
// entry in a final state; get and pop read it in fetch and capture states; insert shifts
// N entries and writes the new one, remove shifts N entries, and move fetches the entry,
// shifts N entries and writes it back (N is at most QUEUE_DEPTH - 1). The shift moves one
// entry per cycle through the single read port and single write port of the entry memory.
// A new command is taken from the cycle after the previous result enters the output register,
// even if that result is still waiting to be taken; a held output register stalls the block.
`default_nettype none

`include "assert_macros.svh"

module reorderable_ring_queue
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_WIDTH = 32
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic [TO_W-1:0]     to_position,
    input  wire logic [DATA_W-1:0]   entry_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic                     ok,
    output logic [DATA_W-1:0]        entry_out,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    mem_ctl_t               mem_ctl;
    logic [IW-1:0]          rd_addr;
    logic [IW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic                   res_valid;
    logic                   res_ready;
    logic                   res_ok;
    logic [ENTRY_WIDTH-1:0] res_entry;
    logic [CW-1:0]          res_count;
    logic [MAX_ENTRY_W-1:0] ent_wide;
    logic [LW-1:0]          cnt_wide;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   ok_reg, ok_next;
    logic [DATA_W-1:0]      entry_out_reg, entry_out_next;
    logic [COUNT_W-1:0]     entry_count_reg, entry_count_next;

    rrq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .action      (action),
        .position    (position),
        .to_position (to_position),
        .entry_data  (entry_data),
        .mem_ctl     (mem_ctl),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_ok      (res_ok),
        .res_entry   (res_entry),
        .res_count   (res_count)
    );

    rrq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign ent_wide  = MAX_ENTRY_W'(res_entry);
    assign cnt_wide  = LW'(res_count);
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        ok_next          = ok_reg;
        entry_out_next   = entry_out_reg;
        entry_count_next = entry_count_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next   = 1'b1;
            ok_next          = res_ok;
            entry_out_next   = ent_wide[DATA_W-1:0];
            entry_count_next = cnt_wide[COUNT_W-1:0];
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg   <= 1'b0;
            ok_reg          <= 1'b0;
            entry_out_reg   <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            rsp_valid_reg   <= rsp_valid_next;
            ok_reg          <= ok_next;
            entry_out_reg   <= entry_out_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = ok_reg;
    assign entry_out   = entry_out_reg;
    assign entry_count = entry_count_reg;

    `RRQ_ASSERT(a_count_range, res_count <= CW'(QUEUE_DEPTH), "entry count above queue depth")
    `RRQ_ASSERT(a_one_item, !(cmd_ready && res_valid), "command taken while a result is staged")
    `RRQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "staged result dropped")
    `RRQ_ASSERT_NEXT(a_rsp_src, !rsp_valid && !(res_valid && res_ready), !rsp_valid, "stray item")

endmodule

`default_nettype wire

// ===== sv/rrq_store.sv =====
`default_nettype none

module rrq_store
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_WIDTH = 32,
    localparam int IW = $clog2(QUEUE_DEPTH)
)
(
    input  wire logic                   clk,
    input  wire mem_ctl_t               mem_ctl,
    input  wire logic [IW-1:0]          rd_addr,
    input  wire logic [IW-1:0]          wr_addr,
    input  wire logic [ENTRY_WIDTH-1:0] wr_data,
    output logic [ENTRY_WIDTH-1:0]      rd_data
);

    logic [ENTRY_WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/rrq_ctrl.sv =====
`default_nettype none

module rrq_ctrl
    import rrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ENTRY_WIDTH = 32,
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire logic [ACTION_W-1:0]    action,
    input  wire logic [POS_W-1:0]       position,
    input  wire logic [TO_W-1:0]        to_position,
    input  wire logic [DATA_W-1:0]      entry_data,
    output mem_ctl_t                    mem_ctl,
    output logic [IW-1:0]               rd_addr,
    output logic [IW-1:0]               wr_addr,
    output logic [ENTRY_WIDTH-1:0]      wr_data,
    input  wire logic [ENTRY_WIDTH-1:0] rd_data,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output logic                        res_ok,
    output logic [ENTRY_WIDTH-1:0]      res_entry,
    output logic [CW-1:0]               res_count
);

    localparam int LW = (CW > POS_W) ? CW : POS_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
    localparam logic [LW:0]   DEPTH_S = (LW + 1)'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CAPTURE,
        S_SHIFT,
        S_FINAL,
        S_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    action_t                op_reg, op_next;
    logic [IW-1:0]          head_reg, head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [LW-1:0]          cur_reg, cur_next;
    logic [LW-1:0]          left_reg, left_next;
    logic [LW-1:0]          wdst_reg, wdst_next;
    logic [LW-1:0]          fpos_reg, fpos_next;
    logic                   up_reg, up_next;
    logic                   pend_reg, pend_next;
    logic                   final_reg, final_next;
    logic [ENTRY_WIDTH-1:0] data_reg, data_next;
    logic                   rok_reg, rok_next;
    logic [ENTRY_WIDTH-1:0] rent_reg, rent_next;

    logic [LW-1:0]          pos_l;
    logic [LW-1:0]          to_l;
    logic [LW-1:0]          cnt_l;
    logic [LW-1:0]          clamp_l;
    logic [LW-1:0]          src_l;
    logic [MAX_ENTRY_W-1:0] din_wide;

    function automatic logic [IW-1:0] slot_of(input logic [LW-1:0] p);
        logic [LW:0] s;
        s = {{(LW - IW + 1){1'b0}}, head_reg} + {1'b0, p};
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IW-1:0];
    endfunction

    assign pos_l    = LW'(position);
    assign to_l     = LW'(to_position);
    assign cnt_l    = LW'(count_reg);
    assign clamp_l  = (pos_l > cnt_l) ? cnt_l : pos_l;
    assign src_l    = up_reg ? (cur_reg - 1'b1) : (cur_reg + 1'b1);
    assign din_wide = MAX_ENTRY_W'(entry_data);

    assign rd_addr  = slot_of((state_reg == S_FETCH) ? cur_reg : src_l);
    assign wr_addr  = slot_of((state_reg == S_FINAL) ? fpos_reg : wdst_reg);
    assign wr_data  = (state_reg == S_FINAL) ? data_reg : rd_data;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res_ok    = rok_reg;
    assign res_entry = rent_reg;
    assign res_count = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        wdst_next     = wdst_reg;
        fpos_next     = fpos_reg;
        up_next       = up_reg;
        pend_next     = pend_reg;
        final_next    = final_reg;
        data_next     = data_reg;
        rok_next      = rok_reg;
        rent_next     = rent_reg;
        mem_ctl       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = action_t'(action);
                    data_next  = din_wide[ENTRY_WIDTH-1:0];
                    rok_next   = 1'b0;
                    rent_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_RESULT;
                    unique case (action_t'(action))
                        ACT_APPEND:
                        begin
                            if (cnt_l < DEPTH_L)
                            begin
                                fpos_next  = cnt_l;
                                rok_next   = 1'b1;
                                state_next = S_FINAL;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (cnt_l < DEPTH_L)
                            begin
                                fpos_next  = clamp_l;
                                cur_next   = cnt_l;
                                left_next  = cnt_l - clamp_l;
                                up_next    = 1'b1;
                                final_next = 1'b1;
                                rok_next   = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (pos_l < cnt_l)
                            begin
                                cur_next   = pos_l;
                                left_next  = cnt_l - pos_l - 1'b1;
                                up_next    = 1'b0;
                                final_next = 1'b0;
                                rok_next   = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_MOVE:
                        begin
                            if ((pos_l < cnt_l) && (to_l < cnt_l))
                            begin
                                rok_next = 1'b1;
                                if (pos_l != to_l)
                                begin
                                    cur_next   = pos_l;
                                    fpos_next  = to_l;
                                    up_next    = (pos_l > to_l);
                                    left_next  = (pos_l > to_l) ? (pos_l - to_l)
                                                                : (to_l - pos_l);
                                    final_next = 1'b1;
                                    state_next = S_FETCH;
                                end
                            end
                        end
                        ACT_GET:
                        begin
                            if (pos_l < cnt_l)
                            begin
                                cur_next   = pos_l;
                                rok_next   = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        ACT_POP:
                        begin
                            if (cnt_l != '0)
                            begin
                                cur_next   = '0;
                                rok_next   = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            rok_next   = 1'b1;
                        end
                        default:
                        begin
                            rok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                state_next = S_RESULT;
                unique case (op_reg)
                    ACT_MOVE:
                    begin
                        data_next  = rd_data;
                        state_next = S_SHIFT;
                    end
                    ACT_GET:
                    begin
                        rent_next = rd_data;
                    end
                    ACT_POP:
                    begin
                        rent_next  = rd_data;
                        head_next  = slot_of(LW'(1));
                        count_next = count_reg - 1'b1;
                    end
                    default:
                    begin
                        rent_next = '0;
                    end
                endcase
            end
            S_SHIFT:
            begin
                if (left_reg != '0)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    wdst_next     = cur_reg;
                    cur_next      = src_l;
                    left_next     = left_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                end
                if ((left_reg == '0) && !pend_reg)
                begin
                    if (final_reg)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESULT;
                    end
                end
            end
            S_FINAL:
            begin
                mem_ctl.wr_en = 1'b1;
                if ((op_reg == ACT_APPEND) || (op_reg == ACT_INSERT))
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ACT_CLEAR;
            head_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= '0;
            left_reg  <= '0;
            wdst_reg  <= '0;
            fpos_reg  <= '0;
            up_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            final_reg <= 1'b0;
            data_reg  <= '0;
            rok_reg   <= 1'b0;
            rent_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            left_reg  <= left_next;
            wdst_reg  <= wdst_next;
            fpos_reg  <= fpos_next;
            up_reg    <= up_next;
            pend_reg  <= pend_next;
            final_reg <= final_next;
            data_reg  <= data_next;
            rok_reg   <= rok_next;
            rent_reg  <= rent_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/reorderable_ring_queue_test.sv =====
`timescale 1ns / 100ps

module reorderable_ring_queue_test
    import rrq_pkg::*;
();

    localparam int DEPTH         = 64;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PLAN_LEN      = 25;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PERCENT  = 36;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 3'd7;

    typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

    typedef struct packed {
        logic               ok;
        logic [DATA_W-1:0]  entry;
        logic [COUNT_W-1:0] count;
    } queue_result_t;

    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [TO_W-1:0]     dest;
        logic [DATA_W-1:0]   word;
        bit                  typed;
        logic                t_ok;
        logic [DATA_W-1:0]   t_entry;
        logic [COUNT_W-1:0]  t_count;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    logic [ACTION_W-1:0] action = '0;
    logic [POS_W-1:0]    position = '0;
    logic [TO_W-1:0]     to_position = '0;
    logic [DATA_W-1:0]   entry_data = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic                ok;
    logic [DATA_W-1:0]   entry_out;
    logic [COUNT_W-1:0]  entry_count;

    logic [DATA_W-1:0]   ring_store [DEPTH];
    logic [5:0]          ring_head = '0;
    logic [COUNT_W-1:0]  ring_fill = '0;

    queue_result_t       pending_results [$];
    int                  mismatch_count = 0;
    int unsigned         cycle_count = 0;
    bit                  calm = 1'b0;
    bit                  hold_wanted = 1'b0;
    bit                  hold_taken = 1'b0;

    plan_row_t directed_plan [PLAN_LEN] = '{
        '{ACT_POP,     7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
        '{ACT_GET,     7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
        '{ACT_REMOVE,  7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
        '{ACT_MOVE,    7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0},
        '{ACT_UNKNOWN, 7'd127, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 7'd0},
        '{ACT_CLEAR,   7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0},
        '{ACT_APPEND,  7'd0,   6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd1},
        '{ACT_APPEND,  7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd2},
        '{ACT_INSERT,  7'd127, 6'd0,  32'hA5A5_5A5A, 1'b1, 1'b1, 32'h0, 7'd3},
        '{ACT_INSERT,  7'd0,   6'd0,  32'h1234_5678, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_GET,     7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 7'd4},
        '{ACT_GET,     7'd3,   6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_GET,     7'd4,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd4},
        '{ACT_GET,     7'd64,  6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd4},
        '{ACT_MOVE,    7'd0,   6'd3,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_MOVE,    7'd3,   6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_MOVE,    7'd1,   6'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_MOVE,    7'd63,  6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd4},
        '{ACT_MOVE,    7'd0,   6'd63, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd4},
        '{ACT_REMOVE,  7'd1,   6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_REMOVE,  7'd3,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd3},
        '{ACT_POP,     7'd0,   6'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_INSERT,  7'd64,  6'd0,  32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0, 7'd0},
        '{ACT_CLEAR,   7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0, 7'd0},
        '{ACT_POP,     7'd0,   6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0, 7'd0}
    };

    reorderable_ring_queue uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .action      (action),
        .position    (position),
        .to_position (to_position),
        .entry_data  (entry_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .ok          (ok),
        .entry_out   (entry_out),
        .entry_count (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int slot_of(int offset);
        return (int'(ring_head) + offset) % DEPTH;
    endfunction

    function automatic queue_result_t apply_command(logic [ACTION_W-1:0] act,
                                                    logic [POS_W-1:0] pos,
                                                    logic [TO_W-1:0] dest,
                                                    logic [DATA_W-1:0] word);
        queue_result_t     res;
        int                p;
        int                d;
        int                fill;
        logic [DATA_W-1:0] moving;
        res  = '0;
        p    = int'(pos);
        d    = int'(dest);
        fill = int'(ring_fill);
        case (act)
            ACT_APPEND:
            begin
                if (fill < DEPTH)
                begin
                    ring_store[slot_of(fill)] = word;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (fill < DEPTH)
                begin
                    if (p > fill)
                        p = fill;
                    for (int i = fill; i > p; i--)
                        ring_store[slot_of(i)] = ring_store[slot_of(i - 1)];
                    ring_store[slot_of(p)] = word;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            ACT_REMOVE:
            begin
                if (p < fill)
                begin
                    for (int i = p; i + 1 < fill; i++)
                        ring_store[slot_of(i)] = ring_store[slot_of(i + 1)];
                    fill--;
                    res.ok = 1'b1;
                end
            end
            ACT_MOVE:
            begin
                if (p < fill && d < fill)
                begin
                    if (p != d)
                    begin
                        moving = ring_store[slot_of(p)];
                        if (p < d)
                        begin
                            for (int i = p; i < d; i++)
                                ring_store[slot_of(i)] = ring_store[slot_of(i + 1)];
                        end
                        else
                        begin
                            for (int i = p; i > d; i--)
                                ring_store[slot_of(i)] = ring_store[slot_of(i - 1)];
                        end
                        ring_store[slot_of(d)] = moving;
                    end
                    res.ok = 1'b1;
                end
            end
            ACT_GET:
            begin
                if (p < fill)
                begin
                    res.entry = ring_store[slot_of(p)];
                    res.ok    = 1'b1;
                end
            end
            ACT_POP:
            begin
                if (fill > 0)
                begin
                    res.entry = ring_store[slot_of(0)];
                    ring_head = 6'(slot_of(1));
                    fill--;
                    res.ok    = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                ring_head = '0;
                fill      = 0;
                res.ok    = 1'b1;
            end
            default:
            begin
            end
        endcase
        ring_fill = COUNT_W'(fill);
        res.count = ring_fill;
        return res;
    endfunction

    function automatic logic [ACTION_W-1:0] pick_action(mix_t mix);
        int weights [6];
        int roll;
        int acc;
        roll = $urandom_range(0, 99);
        if (roll == 0)
            return ACT_UNKNOWN;
        if (roll == 1)
            return ACT_CLEAR;
        case (mix)
            MIX_FILL:     weights = '{45, 30, 5, 8, 7, 5};
            MIX_DRAIN:    weights = '{8, 7, 35, 15, 10, 25};
            default:      weights = '{20, 20, 15, 20, 15, 10};
        endcase
        roll = $urandom_range(0, 99);
        acc  = 0;
        for (int k = 0; k < 6; k++)
        begin
            acc += weights[k];
            if (roll < acc)
                return ACTION_W'(k);
        end
        return ACT_POP;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(logic [ACTION_W-1:0] act);
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, 127));
        if (act == ACT_INSERT)
            return POS_W'($urandom_range(0, ring_fill));
        if (ring_fill == 0)
            return '0;
        return POS_W'($urandom_range(0, ring_fill - 1));
    endfunction

    function automatic logic [TO_W-1:0] pick_destination();
        if ($urandom_range(0, 9) == 0 || ring_fill == 0)
            return TO_W'($urandom_range(0, 63));
        return TO_W'($urandom_range(0, ring_fill - 1));
    endfunction

    task automatic send_command(plan_row_t row);
        queue_result_t want;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        action      <= row.act;
        position    <= row.pos;
        to_position <= row.dest;
        entry_data  <= row.word;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        want = apply_command(row.act, row.pos, row.dest, row.word);
        if (row.typed)
            want = '{ok: row.t_ok, entry: row.t_entry, count: row.t_count};
        pending_results.push_back(want);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with no command waiting for it");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
                    mismatch_count++;
                end
                if (entry_out !== want.entry)
                begin
                    $error("entry_out mismatch: expected %h, actual %h", want.entry, entry_out);
                    mismatch_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           want.count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("reorderable_ring_queue_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        mix_t      mix;
        for (int i = 0; i < DEPTH; i++)
            ring_store[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k])
            send_command(directed_plan[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 500);
            if (n == 1000)
                hold_wanted = 1'b1;
            if (n == 1200)
            begin
                while (pending_results.size() != 0)
                begin
                    cmd_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            case ((n / 120) % 4)
                0:       mix = MIX_FILL;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_BALANCED;
            endcase
            row.act     = pick_action(mix);
            row.pos     = pick_position(row.act);
            row.dest    = pick_destination();
            row.word    = $urandom();
            row.typed   = 1'b0;
            row.t_ok    = 1'b0;
            row.t_entry = '0;
            row.t_count = '0;
            send_command(row);
        end
        cmd_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatch_count == 0)
            $display("reorderable_ring_queue_test: PASS");
        else
            $display("reorderable_ring_queue_test: FAIL");
        $finish;
    end

endmodule
